// File: hw/rtl/gregorian_date_add_days_macros.svh
// ---------------------------------------------------------------------------
// Assertion helpers shared by the queue and back end RTL files.
// ---------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ADD_DAYS_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/gda_pkg.sv
// ---------------------------------------------------------------------------
// gda_pkg
// Types, constants and calendar helpers for the Gregorian date adder.
// ---------------------------------------------------------------------------
package gda_pkg;

    // Field widths
    localparam int IN_YEAR_W = 14;
    localparam int YEAR_W    = IN_YEAR_W + 1;  // headroom: years run past the input range
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int COUNT_W   = 16;
    localparam int LEFT_W    = COUNT_W + 1;    // day count plus starting day

    // First valid date after the calendar reform, split into its parts
    localparam int FIRST_DATE  = 15821015;
    localparam int FIRST_YEAR  = FIRST_DATE / 10000;
    localparam int FIRST_MONTH = (FIRST_DATE / 100) % 100;
    localparam int FIRST_DAY   = FIRST_DATE % 100;

    // Months
    localparam int JANUARY  = 1;
    localparam int FEBRUARY = 2;
    localparam int APRIL    = 4;
    localparam int JUNE     = 6;
    localparam int SEPTEMBER = 9;
    localparam int NOVEMBER = 11;
    localparam int DECEMBER = 12;

    // Month lengths
    localparam int LEN_LONG     = 31;
    localparam int LEN_SHORT    = 30;
    localparam int LEN_FEB      = 28;
    localparam int LEN_FEB_LEAP = 29;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Inverse of an odd number modulo 2**YEAR_W (Newton iteration, elaboration only)
    function automatic logic [YEAR_W-1:0] odd_inverse(input int d);
        logic [YEAR_W-1:0] x;
        logic [YEAR_W-1:0] dd;
        dd = YEAR_W'(d);
        x  = dd;
        for (int i = 0; i < 5; i++) begin
            x = YEAR_W'(x * (YEAR_W'(2) - YEAR_W'(dd * x)));
        end
        return x;
    endfunction

    localparam logic [YEAR_W-1:0] INV25     = odd_inverse(25);
    localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'(((1 << YEAR_W) - 1) / 25);

    // Leap rule: by 4, not by 100 unless by 400.
    // 100 = 4*25 and 400 = 16*25; divisibility by 25 uses the modular inverse.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] prod;
        logic              div4;
        logic              div16;
        logic              div25;
        prod  = YEAR_W'(y * INV25);
        div4  = (y[1:0] == 2'd0);
        div16 = (y[3:0] == 4'd0);
        div25 = (prod <= DIV25_MAX);
        return div4 && (!div25 || div16);
    endfunction

    // Length of a month; codes outside 1..12 read as long months
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            MONTH_W'(FEBRUARY):  len = leap ? DAY_W'(LEN_FEB_LEAP) : DAY_W'(LEN_FEB);
            MONTH_W'(APRIL),
            MONTH_W'(JUNE),
            MONTH_W'(SEPTEMBER),
            MONTH_W'(NOVEMBER):  len = DAY_W'(LEN_SHORT);
            default:             len = DAY_W'(LEN_LONG);
        endcase
        return len;
    endfunction

    // Request payload
    typedef struct packed {
        logic [IN_YEAR_W-1:0] year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        logic [COUNT_W-1:0]   days_to_add;
    } in_item_t;

    // Result payload
    typedef struct packed {
        logic                 date_ok;
        logic [IN_YEAR_W-1:0] result_year;
        logic [MONTH_W-1:0]   result_month;
        logic [DAY_W-1:0]     result_day;
    } out_item_t;

    // Classified request, as queued for the back end
    typedef struct packed {
        logic               ok;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [LEFT_W-1:0]  left;
    } gda_entry_t;

    // Front to queue
    typedef struct packed {
        logic       valid;
        gda_entry_t entry;
    } gda_push_t;

    // Back end sequencer
    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

endpackage

// File: hw/rtl/gda_front.sv
// ---------------------------------------------------------------------------
// gda_front
// Accepts requests, checks the date and registers a classified entry.
// ---------------------------------------------------------------------------
module gda_front
    import gda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  in_item_t  req,
    output gda_push_t push,
    input  logic      push_ready
);

    logic              valid_reg;
    gda_entry_t        entry_reg;
    gda_entry_t        entry_next;
    logic              accept;
    logic [YEAR_W-1:0] year_ext;
    logic              too_early;
    logic              month_bad;
    logic              day_bad;

    // Hold the request while the registered entry cannot move on
    assign req_stall = valid_reg && !push_ready;
    assign accept    = req_valid && !req_stall;

    // Date check; too_early compares year, then month, then day with the
    // first valid date, and the day is checked against its month length
    always_comb
    begin
        year_ext  = {1'b0, req.year};
        too_early = (req.year < IN_YEAR_W'(FIRST_YEAR)) ||
                    ((req.year == IN_YEAR_W'(FIRST_YEAR)) &&
                     ((req.month < MONTH_W'(FIRST_MONTH)) ||
                      ((req.month == MONTH_W'(FIRST_MONTH)) &&
                       (req.day < DAY_W'(FIRST_DAY)))));
        month_bad = (req.month < MONTH_W'(JANUARY)) || (req.month > MONTH_W'(DECEMBER));
        day_bad   = (req.day == '0) ||
                    (req.day > month_len(is_leap(year_ext), req.month));

        if (too_early || month_bad || day_bad)
        begin
            entry_next = '0;
        end
        else
        begin
            entry_next.ok    = 1'b1;
            entry_next.year  = year_ext;
            entry_next.month = req.month;
            entry_next.left  = LEFT_W'(req.days_to_add) + LEFT_W'(req.day);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= entry_next;
        end
    end

    assign push.valid = valid_reg;
    assign push.entry = entry_reg;

endmodule

// File: hw/rtl/gda_queue.sv
// ---------------------------------------------------------------------------
// gda_queue
// Short FIFO of classified entries between the front and the back end.
// ---------------------------------------------------------------------------
`include "gregorian_date_add_days_macros.svh"

module gda_queue
    import gda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  gda_push_t  push,
    output logic       push_ready,
    output logic       q_valid,
    output gda_entry_t q_entry,
    input  logic       q_pop
);

    gda_entry_t        entry_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid    = (cnt_reg != '0);
    assign q_entry    = entry_mem[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = q_pop && q_valid;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_mem[wr_ptr_reg] <= push.entry;
        end
    end

    `GDA_ASSERT_NEXT(a_q_fill, do_push && !do_pop, cnt_reg == $past(cnt_reg) + 1'b1, "queue count did not grow on push")

endmodule

// File: hw/rtl/gda_back.sv
// ---------------------------------------------------------------------------
// gda_back
// Walks the day count forward one month per cycle and registers the result.
// ---------------------------------------------------------------------------
`include "gregorian_date_add_days_macros.svh"

module gda_back
    import gda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  gda_entry_t q_entry,
    output logic       q_pop,
    output logic       res_valid,
    input  logic       res_stall,
    output out_item_t  res
);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic               ok_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [LEFT_W-1:0]  left_reg;
    logic               res_valid_reg;
    out_item_t          res_reg;
    logic [DAY_W-1:0]   cur_len;
    logic               fits;
    logic               out_free;
    logic               load_out;
    logic               step;

    // Current month length and stop test
    assign cur_len  = month_len(is_leap(year_reg), month_reg);
    assign fits     = !ok_reg || (left_reg <= LEFT_W'(cur_len));
    assign out_free = !res_valid_reg || !res_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (q_valid) state_next = BK_RUN;
            BK_RUN:  if (fits && out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        step     = 1'b0;
        unique case (state_reg)
            BK_IDLE: q_pop = q_valid;
            BK_RUN:
            begin
                load_out = fits && out_free;
                step     = !fits;
            end
            default: q_pop = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Working date: load, then take off one month per step
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ok_reg    <= q_entry.ok;
            year_reg  <= q_entry.year;
            month_reg <= q_entry.month;
            left_reg  <= q_entry.left;
        end
        else if (step)
        begin
            left_reg <= left_reg - LEFT_W'(cur_len);
            if (month_reg == MONTH_W'(DECEMBER))
            begin
                month_reg <= MONTH_W'(JANUARY);
                year_reg  <= year_reg + 1'b1;
            end
            else
            begin
                month_reg <= month_reg + 1'b1;
            end
        end
    end

    // Result register; an invalid date gives all-zero fields
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (ok_reg)
            begin
                res_reg.date_ok      <= 1'b1;
                res_reg.result_year  <= year_reg[IN_YEAR_W-1:0];
                res_reg.result_month <= month_reg;
                res_reg.result_day   <= left_reg[DAY_W-1:0];
            end
            else
            begin
                res_reg <= '0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `GDA_ASSERT_NEXT(a_step_shrinks, step, left_reg < $past(left_reg), "day count did not shrink on a month step")
    `GDA_ASSERT_NOW(a_ok_range, res_valid_reg && res_reg.date_ok, (res_reg.result_day != '0) && (res_reg.result_month >= MONTH_W'(JANUARY)) && (res_reg.result_month <= MONTH_W'(DECEMBER)), "valid result out of calendar range")
    `GDA_ASSERT_NOW(a_bad_zero, res_valid_reg && !res_reg.date_ok, (res_reg.result_year == '0) && (res_reg.result_month == '0) && (res_reg.result_day == '0), "invalid date gave nonzero fields")

endmodule

// File: hw/rtl/gregorian_date_add_days.sv
// ---------------------------------------------------------------------------
// gregorian_date_add_days
// Gregorian date plus a day count, with date check.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel req_valid / req_stall / req carries year, month, day and
//   days_to_add. A request is taken at a clock edge with req_valid high and
//   req_stall low. Result channel res_valid / res_stall / res carries
//   date_ok and the resulting year, month and day; all zero when the date is
//   invalid (before 1582-10-15, month outside 1..12, day outside the month).
//   Flow: the front registers a checked request, a two-entry queue holds it,
//   and the back end takes off one month per cycle. An item whose result
//   lands k months later takes k month steps in the back end, and k is at
//   most about 2160 for the largest day count. The back end takes a new
//   item from the queue only after the last result is loaded into the
//   output register.
//   The front and queue keep taking requests while a result waits in the
//   output register; when the receiver stalls, the result holds and the back
//   end waits, and the queue fills until the front stalls requests.
//   Reset (rst_n low, asynchronous) empties the queue, idles the back end and
//   drops any pending result.
// ---------------------------------------------------------------------------
module gregorian_date_add_days
    import gda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  in_item_t  req,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res
);

    gda_push_t  push;
    logic       push_ready;
    logic       q_valid;
    gda_entry_t q_entry;
    logic       q_pop;

    // Request check
    gda_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .push       (push),
        .push_ready (push_ready)
    );

    // Decoupling queue
    gda_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_pop      (q_pop)
    );

    // Month stepping and result
    gda_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_pop      (q_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule
